// File: sv/twre_pkg.sv
package twre_pkg;

    localparam logic [15:0] TAG_RESET       = 16'hFEFE;
    localparam logic [2:0]  MIN_RUN_RESET   = 3'd4;
    localparam logic [2:0]  MIN_RUN_CAP     = 3'd4;
    localparam logic [15:0] RUN_VALUE_RESET = 16'hFFFF;
    localparam logic [15:0] LENGTH_MAX      = 16'hFFFF;
    localparam logic [1:0]  RECORD_LAST_IDX = 2'd2;
    localparam int          QUEUE_DEPTH     = 4;

    localparam logic REG_TAG_WORD    = 1'b0;
    localparam logic REG_MIN_TAG_RUN = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        rec;
        logic [15:0] count;
        logic [15:0] value;
    } run_t;

    typedef struct packed {
        run_t a;
        run_t b;
    } burst_t;

endpackage

// File: sv/tagged_word_rle_encoder.sv
// Run-length encoder for a stream of 16-bit words. One input word is taken per cycle
// while the internal burst queue has room; each closed run leaves as a tag record
// (tag, count, value) or as up to three literal copies, one output word per cycle while
// out_stall is low, so a sustained input rate of one word per cycle holds as long as
// the encoded stream is no longer than the input. The queue depth (QUEUE_DEPTH bursts)
// sets how long the input keeps flowing while the output side is stalled or busy.
module tagged_word_rle_encoder
    import twre_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] in_word,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_word,
    output logic        last_of_burst
);

    logic [15:0] tag_word_reg;
    logic [2:0]  min_tag_run_reg;
    logic        accept;
    logic        push;
    logic        pop;
    logic        empty;
    logic        full;
    logic        run_open;
    burst_t      burst;
    burst_t      head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_word_reg    <= TAG_RESET;
            min_tag_run_reg <= MIN_RUN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAG_WORD:    tag_word_reg    <= cfg_data;
                REG_MIN_TAG_RUN: min_tag_run_reg <= cfg_data[2:0];
                default:         tag_word_reg    <= tag_word_reg;
            endcase
        end
    end

    assign in_stall = full;
    assign accept   = in_valid && !full;

    twre_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .tag_word      (tag_word_reg),
        .min_tag_run   (min_tag_run_reg),
        .accept        (accept),
        .in_word       (in_word),
        .end_of_stream (end_of_stream),
        .push          (push),
        .burst         (burst),
        .run_open      (run_open)
    );

    twre_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (burst),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    twre_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .tag_word      (tag_word_reg),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word),
        .last_of_burst (last_of_burst)
    );

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Burst pushed into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("Burst popped from an empty queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_stream) |=> !run_open)
        else $error("Run still open after the end of the stream.");

endmodule

// File: sv/twre_front.sv
module twre_front
    import twre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] tag_word,
    input  logic [2:0]  min_tag_run,
    input  logic        accept,
    input  logic [15:0] in_word,
    input  logic        end_of_stream,
    output logic        push,
    output burst_t      burst,
    output logic        run_open
);

    logic [15:0] run_value_reg;
    logic [15:0] run_value_next;
    logic [15:0] run_length_reg;
    logic [15:0] run_length_next;
    logic [2:0]  thr;
    logic [15:0] len_inc;
    logic [15:0] mid_value;
    logic [15:0] mid_length;

    always_comb
    begin
        if (min_tag_run == 3'd0)
        begin
            thr = 3'd1;
        end
        else if (min_tag_run inside {[3'd5:3'd7]})
        begin
            thr = MIN_RUN_CAP;
        end
        else
        begin
            thr = min_tag_run;
        end
    end

    always_comb
    begin
        len_inc    = run_length_reg + 16'd1;
        burst      = '0;
        mid_value  = run_value_reg;
        mid_length = run_length_reg;

        if (run_length_reg == 16'd0)
        begin
            mid_value  = in_word;
            mid_length = 16'd1;
        end
        else if (in_word != run_value_reg)
        begin
            burst.a.valid = 1'b1;
            burst.a.value = run_value_reg;
            burst.a.count = run_length_reg;
            mid_value     = in_word;
            mid_length    = 16'd1;
        end
        else if (len_inc == LENGTH_MAX)
        begin
            burst.a.valid = 1'b1;
            burst.a.value = run_value_reg;
            burst.a.count = LENGTH_MAX;
            mid_length    = 16'd0;
        end
        else
        begin
            mid_length = len_inc;
        end

        burst.a.rec = (burst.a.value == tag_word) || (burst.a.count >= {13'd0, thr});

        run_value_next  = mid_value;
        run_length_next = mid_length;
        if (end_of_stream)
        begin
            if (mid_length != 16'd0)
            begin
                burst.b.valid = 1'b1;
                burst.b.value = mid_value;
                burst.b.count = mid_length;
            end
            run_value_next  = RUN_VALUE_RESET;
            run_length_next = 16'd0;
        end

        burst.b.rec = (burst.b.value == tag_word) || (burst.b.count >= {13'd0, thr});
    end

    assign push     = accept && (burst.a.valid || burst.b.valid);
    assign run_open = (run_length_reg != 16'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg  <= RUN_VALUE_RESET;
            run_length_reg <= 16'd0;
        end
        else if (accept)
        begin
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
        end
    end

endmodule

// File: sv/twre_queue.sv
module twre_queue
    import twre_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  burst_t push_data,
    input  logic   pop,
    output burst_t head,
    output logic   empty,
    output logic   full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    burst_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// File: sv/twre_back.sv
module twre_back
    import twre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] tag_word,
    input  burst_t      head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_word,
    output logic        last_of_burst
);

    logic        phase_reg;
    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    logic [15:0] out_word_reg;
    logic        last_reg;
    logic        use_b;
    run_t        sel;
    logic [1:0]  last_idx;
    logic [15:0] word;
    logic        run_last;
    logic        burst_last;
    logic        advance;

    always_comb
    begin
        use_b    = phase_reg || !head.a.valid;
        sel      = use_b ? head.b : head.a;
        last_idx = sel.rec ? RECORD_LAST_IDX : (sel.count[1:0] - 2'd1);
        if (sel.rec && (idx_reg == 2'd0))
        begin
            word = tag_word;
        end
        else if (sel.rec && (idx_reg == 2'd1))
        begin
            word = sel.count;
        end
        else
        begin
            word = sel.value;
        end
        run_last   = (idx_reg == last_idx);
        burst_last = run_last && (use_b || !head.b.valid);
        advance    = !empty && (!out_valid_reg || !out_stall);
    end

    assign pop           = advance && burst_last;
    assign out_valid     = out_valid_reg;
    assign out_word      = out_word_reg;
    assign last_of_burst = last_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= word;
            last_reg     <= burst_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            if (run_last)
            begin
                idx_reg   <= 2'd0;
                phase_reg <= !burst_last;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
